// ----- rtl/swm_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the separable window filter
package swm_pkg;

  localparam int HEIGHT_BITS    = 13;
  localparam int MAX_HEIGHT     = 4096;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  localparam int WIDTH_BITS_CFG  = 11;
  localparam int RADIUS_BITS_CFG = 4;

  localparam logic [WIDTH_BITS_CFG-1:0]  WIDTH_RESET  = 11'd256;
  localparam logic [HEIGHT_BITS-1:0]     HEIGHT_RESET = 13'd256;
  localparam logic [RADIUS_BITS_CFG-1:0] RADIUS_RESET = 4'd4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 4'd0,
    REG_IMAGE_HEIGHT  = 4'd1,
    REG_WINDOW_RADIUS = 4'd2,
    REG_FILTER_MODE   = 4'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HRD,
    S_HACC,
    S_HDIV,
    S_VACC,
    S_VDIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cfg_wr;
    logic rd;
    logic hacc;
    logic col_next;
    logic row_next;
    logic vacc;
    logic div_start;
    logic div_src_v;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic j_last;
    logic i_last;
    logic div_done;
    logic out_free;
    logic mean;
  } status_t;

endpackage

// ----- rtl/swm_ifs.sv -----
`timescale 1ns / 1ps
// request channel interfaces: sample input, filtered output, register writes
interface swm_in_if #(parameter int VALUE_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sample;
  logic                  drain;
  modport source (output valid, output sample, output drain, input ready);
  modport sink (input valid, input sample, input drain, output ready);
endinterface

interface swm_out_if #(parameter int VALUE_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] filtered;
  logic                  frame_end;
  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

interface swm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/swm_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer that walks the window for each request that yields a result
module swm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             cfg_valid,
  output logic             in_ready,
  output logic             cfg_ready,
  input  swm_pkg::status_t st,
  output swm_pkg::cmd_t    cmd
);
  import swm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.emit) state_next = S_HRD;
        end
      end
      S_HRD: begin
        cmd.rd     = 1'b1;
        state_next = S_HACC;
      end
      S_HACC: begin
        cmd.hacc = 1'b1;
        if (st.j_last) begin
          if (st.mean) begin
            cmd.div_start = 1'b1;
            state_next    = S_HDIV;
          end else begin
            state_next = S_VACC;
          end
        end else begin
          cmd.col_next = 1'b1;
          state_next   = S_HRD;
        end
      end
      S_HDIV: begin
        if (st.div_done) state_next = S_VACC;
        else cmd.div_step = 1'b1;
      end
      S_VACC: begin
        cmd.vacc = 1'b1;
        if (st.i_last) begin
          if (st.mean) begin
            cmd.div_start = 1'b1;
            cmd.div_src_v = 1'b1;
            state_next    = S_VDIV;
          end else begin
            state_next = S_OUT;
          end
        end else begin
          cmd.row_next = 1'b1;
          state_next   = S_HRD;
        end
      end
      S_VDIV: begin
        if (st.div_done) state_next = S_OUT;
        else cmd.div_step = 1'b1;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/swm_dp.sv -----
`timescale 1ns / 1ps
// datapath: counters, sample store, window accumulators, divider, output register
module swm_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8,
  parameter int VALUE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  swm_pkg::cmd_t                      cmd,
  output swm_pkg::status_t                   st,
  input  logic [VALUE_BITS-1:0]              in_sample,
  input  logic                               in_drain,
  input  logic [swm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [swm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [VALUE_BITS-1:0]              out_filtered,
  output logic                               out_frame_end
);
  import swm_pkg::*;

  localparam int DEPTH = MAX_WIDTH * 2 * MAX_RADIUS + 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RB    = $clog2(MAX_RADIUS + 1);
  localparam int KB    = $clog2(2 * MAX_RADIUS + 1);
  localparam int DLW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int QW    = $clog2(MAX_HEIGHT * MAX_WIDTH + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int IRW   = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int SUMW  = VALUE_BITS + $clog2(2 * MAX_RADIUS + 1) + 1;
  localparam int DVW   = $clog2(2 * MAX_RADIUS + 2);
  localparam int DCW   = $clog2(SUMW + 1);
  localparam int SX    = WW + 2;
  localparam int SY    = HEIGHT_BITS + 2;

  // configuration
  logic [WIDTH_BITS_CFG-1:0]  cfg_width;
  logic [HEIGHT_BITS-1:0]     cfg_height;
  logic [RADIUS_BITS_CFG-1:0] cfg_radius;
  logic                       cfg_mode;

  logic [WW-1:0]          w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [RB-1:0]          r_eff;
  logic [DLW-1:0]         delay;

  // frame counters
  logic [QW-1:0]          q;
  logic [AW-1:0]          wp;
  logic [WW-1:0]          in_col;
  logic [IRW-1:0]         in_row;
  logic [WW-1:0]          ox;
  logic [HEIGHT_BITS-1:0] oy;

  // window walk
  logic [WW-1:0]          px;
  logic [HEIGHT_BITS-1:0] py;
  logic                   plast;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          row_start;
  logic [KB-1:0]          i;
  logic [KB-1:0]          j;
  logic [SUMW-1:0]        hacc;
  logic [SUMW-1:0]        vacc;
  logic [SUMW-1:0]        hacc_next;
  logic [SUMW-1:0]        vacc_next;
  logic [VALUE_BITS-1:0]  rdata;
  logic                   vflag;

  // divider
  logic [SUMW-1:0]        dvd;
  logic [DVW-1:0]         rem;
  logic [DCW-1:0]         dcnt;
  logic [DVW-1:0]         dsr;
  logic [DVW:0]           dtry;
  logic                   dge;
  logic [VALUE_BITS-1:0]  quo;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  logic              ignore;
  logic              emit;
  logic              last;
  logic              wr_en;
  logic [AW:0]       start_tmp;
  logic [AW-1:0]     start_addr;
  logic [AW:0]       row_sum;
  logic [AW-1:0]     row_adv;
  logic [SX-1:0]     col_s;
  logic [SY-1:0]     row_s;
  logic              elem_ok;
  logic [VALUE_BITS-1:0] elem;
  logic [SUMW-1:0]   div_src;

  always_comb begin
    if (cfg_width == '0) w_eff = WW'(1);
    else if (32'(cfg_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_width);
    if (cfg_height == '0) h_eff = HEIGHT_BITS'(1);
    else if (32'(cfg_height) > MAX_HEIGHT) h_eff = HEIGHT_BITS'(MAX_HEIGHT);
    else h_eff = cfg_height;
    if (32'(cfg_radius) > MAX_RADIUS) r_eff = RB'(MAX_RADIUS);
    else r_eff = RB'(cfg_radius);
  end

  assign delay  = DLW'(r_eff) * DLW'(w_eff) + DLW'(r_eff);
  assign ignore = in_drain && (q == '0);
  assign emit   = !ignore && (q >= QW'(delay));
  assign last   = (ox == w_eff - WW'(1)) && (oy == h_eff - HEIGHT_BITS'(1));
  assign wr_en  = cmd.accept && !ignore && (in_row < IRW'(h_eff));

  assign start_tmp  = (AW + 1)'(wp) - ((AW + 1)'(delay) << 1);
  assign start_addr = start_tmp[AW] ? AW'(start_tmp + (AW + 1)'(DEPTH)) : AW'(start_tmp);
  assign row_sum    = (AW + 1)'(row_start) + (AW + 1)'(w_eff);
  assign row_adv    = (row_sum >= (AW + 1)'(DEPTH)) ? AW'(row_sum - (AW + 1)'(DEPTH))
                                                    : AW'(row_sum);

  assign col_s   = SX'(px) + SX'(j) - SX'(r_eff);
  assign row_s   = SY'(py) + SY'(i) - SY'(r_eff);
  assign elem_ok = !col_s[SX-1] && (col_s < SX'(w_eff)) &&
                   !row_s[SY-1] && (row_s < SY'(h_eff));
  assign elem    = vflag ? rdata : '0;

  assign quo = VALUE_BITS'(dvd);

  always_comb begin
    if (cfg_mode) hacc_next = hacc + SUMW'(elem);
    else hacc_next = (SUMW'(elem) > hacc) ? SUMW'(elem) : hacc;
    if (cfg_mode) vacc_next = vacc + SUMW'(quo);
    else vacc_next = (hacc > vacc) ? hacc : vacc;
  end

  assign div_src = cmd.div_src_v ? vacc_next : hacc_next;
  assign dsr     = DVW'({r_eff, 1'b0}) + DVW'(1);
  assign dtry    = {rem, dvd[SUMW-1]};
  assign dge     = dtry >= (DVW + 1)'(dsr);

  assign st.emit     = emit;
  assign st.j_last   = (j == KB'({r_eff, 1'b0}));
  assign st.i_last   = (i == KB'({r_eff, 1'b0}));
  assign st.div_done = (dcnt == '0);
  assign st.out_free = !out_valid || out_ready;
  assign st.mean     = cfg_mode;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      cfg_radius <= RADIUS_RESET;
      cfg_mode   <= 1'b0;
    end else if (cmd.cfg_wr) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_width  <= cfg_data[WIDTH_BITS_CFG-1:0];
        REG_IMAGE_HEIGHT:  cfg_height <= cfg_data[HEIGHT_BITS-1:0];
        REG_WINDOW_RADIUS: cfg_radius <= cfg_data[RADIUS_BITS_CFG-1:0];
        REG_FILTER_MODE:   cfg_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // frame position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      q      <= '0;
      wp     <= '0;
      in_col <= '0;
      in_row <= '0;
      ox     <= '0;
      oy     <= '0;
    end else if (cmd.cfg_wr) begin
      if (cfg_index <= CFG_INDEX_BITS'(REG_FILTER_MODE)) begin
        q      <= '0;
        wp     <= '0;
        in_col <= '0;
        in_row <= '0;
        ox     <= '0;
        oy     <= '0;
      end
    end else if (cmd.accept && !ignore) begin
      if (emit && last) begin
        q      <= '0;
        wp     <= '0;
        in_col <= '0;
        in_row <= '0;
        ox     <= '0;
        oy     <= '0;
      end else begin
        if (emit) begin
          if (ox == w_eff - WW'(1)) begin
            ox <= '0;
            oy <= oy + HEIGHT_BITS'(1);
          end else begin
            ox <= ox + WW'(1);
          end
        end
        if (in_col == w_eff - WW'(1)) begin
          in_col <= '0;
          in_row <= in_row + IRW'(1);
        end else begin
          in_col <= in_col + WW'(1);
        end
        q  <= q + QW'(1);
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= in_drain ? '0 : in_sample;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[rd_addr];
      vflag <= elem_ok;
    end
  end

  // window walk state
  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      px        <= ox;
      py        <= oy;
      plast     <= last;
      rd_addr   <= start_addr;
      row_start <= start_addr;
      i         <= '0;
      j         <= '0;
      hacc      <= '0;
      vacc      <= '0;
    end else begin
      if (cmd.hacc) hacc <= hacc_next;
      if (cmd.col_next) begin
        j       <= j + KB'(1);
        rd_addr <= (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + AW'(1);
      end
      if (cmd.vacc) vacc <= vacc_next;
      if (cmd.row_next) begin
        i         <= i + KB'(1);
        j         <= '0;
        hacc      <= '0;
        row_start <= row_adv;
        rd_addr   <= row_adv;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DCW'(SUMW);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= div_src + SUMW'(r_eff);
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= dge ? DVW'(dtry - (DVW + 1)'(dsr)) : DVW'(dtry);
      dvd <= {dvd[SUMW-2:0], dge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_filtered  <= cfg_mode ? quo : VALUE_BITS'(vacc);
      out_frame_end <= plast;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp < AW'(DEPTH))
    else $error("write pointer out of store range");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (dcnt != '0))
    else $error("divider stepped past its last bit");

endmodule

// ----- rtl/separable_window_max_or_mean.sv -----
`timescale 1ns / 1ps
// top level of the separable window max or mean filter
//
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | sample, drain
//  out_ch   | out | valid/ready  | filtered, frame_end
//  cfg      | in  | valid/ready  | index, data
//
// a request that yields no result is taken in the idle state, which it does not leave
// a result walks the window row by row with one store read per window element, as the store
// has one read port; in mean mode each row sum and then the column sum pass through a divider
// that yields one quotient bit per cycle, while max mode uses no divider
// rst clears configuration to its defaults and the frame counters; the store is not cleared
// a result waits in the output register while the next request is taken
module separable_window_max_or_mean #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8,
  parameter int VALUE_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg
);
  import swm_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;
  logic    cfg_ready;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .cfg_valid (cfg.valid),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  swm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_sample     (in_ch.sample),
    .in_drain      (in_ch.drain),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_filtered  (out_ch.filtered),
    .out_frame_end (out_ch.frame_end)
  );

  assign in_ch.ready = in_ready;
  assign cfg.ready   = cfg_ready;

endmodule
